// ----- rtl/rmid_pkg.sv -----
// Types and constants shared by the register-mapped divider.
package rmid_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned SEL_W  = 3;
    localparam int unsigned CNT_W  = $clog2(DATA_W);

    typedef enum logic {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } cmd_t;

    typedef enum logic [SEL_W-1:0] {
        SEL_UDIVIDEND = 3'd0,
        SEL_UDIVISOR  = 3'd1,
        SEL_SDIVIDEND = 3'd2,
        SEL_SDIVISOR  = 3'd3,
        SEL_QUOTIENT  = 3'd4,
        SEL_REMAINDER = 3'd5,
        SEL_STATUS    = 3'd6
    } reg_sel_t;

    // Operands handed to the divide unit on start
    typedef struct packed {
        logic              is_signed;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] quotient;
        logic [DATA_W-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- rtl/rmid_if.sv -----
// Valid/ready channel interfaces for bus accesses and read data.
interface rmid_req_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [rmid_pkg::SEL_W-1:0]  reg_select;
    logic [rmid_pkg::DATA_W-1:0] write_data;

    modport source (output valid, output command, output reg_select, output write_data,
                    input ready);
    modport sink   (input valid, input command, input reg_select, input write_data,
                    output ready);
endinterface

interface rmid_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [rmid_pkg::DATA_W-1:0] read_data;

    modport source (output valid, output read_data, input ready);
    modport sink   (input valid, input read_data, output ready);
endinterface

// ----- rtl/rmid_div_core.sv -----
// Radix-2 restoring divide unit with sign fix-up, one quotient bit per cycle.
module rmid_div_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  rmid_pkg::div_req_t  req_in,
    output rmid_pkg::div_stat_t stat,
    output rmid_pkg::div_rsp_t  rsp_out
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIX  = 3'b100
    } state_t;

    localparam int unsigned W = rmid_pkg::DATA_W;

    state_t                       state_reg, state_next;
    logic [rmid_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [W-1:0]                 rem_reg, rem_next;
    logic [W-1:0]                 quo_reg, quo_next;
    logic [W-1:0]                 dsr_reg, dsr_next;
    logic                         n_neg_reg, n_neg_next;
    logic                         d_neg_reg, d_neg_next;

    logic                         n_neg_in;
    logic                         d_neg_in;
    logic [W-1:0]                 abs_n;
    logic [W-1:0]                 abs_d;
    logic [W:0]                   shifted;
    logic [W+1:0]                 diff;
    logic                         fits;

    assign n_neg_in = req_in.is_signed & req_in.dividend[W-1];
    assign d_neg_in = req_in.is_signed & req_in.divisor[W-1];
    assign abs_n    = n_neg_in ? (~req_in.dividend + 1'b1) : req_in.dividend;
    assign abs_d    = d_neg_in ? (~req_in.divisor + 1'b1) : req_in.divisor;

    // Trial subtract of the divisor from the partial remainder shifted by one bit
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dsr_reg};
    assign fits    = ~diff[W+1];

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dsr_next   = dsr_reg;
        n_neg_next = n_neg_reg;
        d_neg_next = d_neg_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                    count_next = '0;
                    rem_next   = '0;
                    quo_next   = abs_n;
                    dsr_next   = abs_d;
                    n_neg_next = n_neg_in;
                    d_neg_next = d_neg_in;
                end
            end
            ST_RUN:
            begin
                rem_next   = fits ? diff[W-1:0] : shifted[W-1:0];
                quo_next   = {quo_reg[W-2:0], fits};
                count_next = count_reg + 1'b1;
                if (count_reg == rmid_pkg::CNT_W'(W - 1))
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dsr_reg   <= dsr_next;
        n_neg_reg <= n_neg_next;
        d_neg_reg <= d_neg_next;
    end

    // Zero divisor and the overflow case fall out of the plain magnitude divide
    assign rsp_out.quotient  = (n_neg_reg ^ d_neg_reg) ? (~quo_reg + 1'b1) : quo_reg;
    assign rsp_out.remainder = n_neg_reg ? (~rem_reg + 1'b1) : rem_reg;

    assign stat.busy = (state_reg != ST_IDLE);
    assign stat.done = (state_reg == ST_FIX);

endmodule

// ----- rtl/register_mapped_int_divider.sv -----
// Top level of the register-mapped 32-bit signed/unsigned divider.
//
//  channel | dir | beat payload                       | handshake
//  --------+-----+------------------------------------+-------------
//  req     | in  | command, reg_select, write_data    | valid/ready
//  rsp     | out | read_data                          | valid/ready
//
// Every accepted access returns one rsp beat in the next cycle.
// A dividend or divisor write loads the divide unit in the accept cycle; the unit
// then runs 32 radix-2 steps in the shared subtractor and a sign fix-up state;
// req.ready stays low until the new quotient and remainder are stored.
// rsp is a register, so a new req is taken while a beat waits only if rsp.ready
// frees it in that cycle. Reset clears all state but the rsp data register and the divide datapath.
module register_mapped_int_divider (
    input  logic clk,
    input  logic rst_n,
    rmid_req_if.sink   req,
    rmid_rsp_if.source rsp
);

    localparam int unsigned W = rmid_pkg::DATA_W;

    logic [W-1:0] dividend_reg, dividend_next;
    logic [W-1:0] divisor_reg, divisor_next;
    logic [W-1:0] quotient_reg, quotient_next;
    logic [W-1:0] remainder_reg, remainder_next;
    logic         dirty_reg, dirty_next;
    logic         rsp_valid_reg, rsp_valid_next;
    logic [W-1:0] rsp_data_reg, rsp_data_next;

    logic                 accept;
    logic                 div_launch;
    rmid_pkg::div_req_t   div_req;
    rmid_pkg::div_rsp_t   div_rsp;
    rmid_pkg::div_stat_t  div_stat;
    rmid_pkg::reg_sel_t   sel;
    rmid_pkg::cmd_t       cmd;

    assign sel    = rmid_pkg::reg_sel_t'(req.reg_select);
    assign cmd    = rmid_pkg::cmd_t'(req.command);
    assign accept = req.valid && req.ready;

    assign req.ready = !div_stat.busy && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        dividend_next  = dividend_reg;
        divisor_next   = divisor_reg;
        quotient_next  = quotient_reg;
        remainder_next = remainder_reg;
        dirty_next     = dirty_reg;
        rsp_data_next  = rsp_data_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        div_launch     = 1'b0;
        div_req.is_signed = 1'b0;

        if (div_stat.done)
        begin
            quotient_next  = div_rsp.quotient;
            remainder_next = div_rsp.remainder;
            dirty_next     = 1'b1;
        end

        if (accept)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = '0;
            unique case (cmd)
                rmid_pkg::CMD_WRITE:
                begin
                    unique case (sel)
                        rmid_pkg::SEL_UDIVIDEND:
                        begin
                            dividend_next = req.write_data;
                            div_launch    = 1'b1;
                        end
                        rmid_pkg::SEL_UDIVISOR:
                        begin
                            divisor_next = req.write_data;
                            div_launch   = 1'b1;
                        end
                        rmid_pkg::SEL_SDIVIDEND:
                        begin
                            dividend_next     = req.write_data;
                            div_launch        = 1'b1;
                            div_req.is_signed = 1'b1;
                        end
                        rmid_pkg::SEL_SDIVISOR:
                        begin
                            divisor_next      = req.write_data;
                            div_launch        = 1'b1;
                            div_req.is_signed = 1'b1;
                        end
                        rmid_pkg::SEL_QUOTIENT:  quotient_next  = req.write_data;
                        rmid_pkg::SEL_REMAINDER: remainder_next = req.write_data;
                        default: ;
                    endcase
                end
                rmid_pkg::CMD_READ:
                begin
                    unique case (sel)
                        rmid_pkg::SEL_UDIVIDEND,
                        rmid_pkg::SEL_SDIVIDEND: rsp_data_next = dividend_reg;
                        rmid_pkg::SEL_UDIVISOR,
                        rmid_pkg::SEL_SDIVISOR:  rsp_data_next = divisor_reg;
                        rmid_pkg::SEL_QUOTIENT:
                        begin
                            rsp_data_next = quotient_reg;
                            dirty_next    = 1'b0;
                        end
                        rmid_pkg::SEL_REMAINDER: rsp_data_next = remainder_reg;
                        rmid_pkg::SEL_STATUS:    rsp_data_next = {{(W-2){1'b0}}, dirty_reg, 1'b0};
                        default:                 rsp_data_next = '0;
                    endcase
                end
                default: ;
            endcase
        end

        div_req.dividend = dividend_next;
        div_req.divisor  = divisor_next;
    end

    rmid_div_core u_div_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_launch),
        .req_in  (div_req),
        .stat    (div_stat),
        .rsp_out (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dividend_reg  <= '0;
            divisor_reg   <= '0;
            quotient_reg  <= '0;
            remainder_reg <= '0;
            dirty_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            dividend_reg  <= dividend_next;
            divisor_reg   <= divisor_next;
            quotient_reg  <= quotient_next;
            remainder_reg <= remainder_next;
            dirty_reg     <= dirty_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.read_data = rsp_data_reg;

endmodule
